// ===== sv/fct_pkg.sv =====
// Shared types and constants for the frustum cull test block.
package fct_pkg;

   // field widths of the query and plane encodings
   localparam int FCT_COORD_BITS    = 16;
   localparam int FCT_FRAC_BITS     = 14;
   localparam int FCT_COEF_BITS     = 16;
   localparam int FCT_PLANES        = 6;

   // configuration port: 64-bit registers at byte address 8*i
   localparam int FCT_CSR_DATA_BITS = 64;
   localparam int FCT_CSR_ADDR_BITS = 6;
   localparam int FCT_CSR_IDX_LSB   = 3;
   localparam int FCT_CSR_IDX_BITS  = FCT_CSR_ADDR_BITS - FCT_CSR_IDX_LSB;

   // query kinds
   localparam logic [1:0] KIND_POINT  = 2'd0;
   localparam logic [1:0] KIND_BOX    = 2'd1;
   localparam logic [1:0] KIND_SPHERE = 2'd2;

   // one query item
   typedef struct packed {
      logic [1:0]                           kind;
      logic signed [FCT_COORD_BITS-1:0]     center_x;
      logic signed [FCT_COORD_BITS-1:0]     center_y;
      logic signed [FCT_COORD_BITS-1:0]     center_z;
      logic [FCT_COORD_BITS-2:0]            half_x;
      logic [FCT_COORD_BITS-2:0]            half_y;
      logic [FCT_COORD_BITS-2:0]            half_z;
      logic [FCT_COORD_BITS-2:0]            radius;
   } fct_req_type;

   // one result item
   typedef struct packed {
      logic visible;
      logic fully_inside;
   } fct_rsp_type;

endpackage

// ===== sv/frustum_cull_test.sv =====
// Six-plane frustum cull test for points, boxes and spheres, five-stage pipeline.
//
//   channel   ports                         handshake
//   -------   ---------------------------   -----------------------------------
//   query     start, busy, req_data          taken when start is high, busy low
//   result    rsp_valid, rsp_data            one-cycle strobe, cannot be stalled
//   csr       csr_psel .. csr_pready (APB)   written on access phase, no waits
//
// One item enters per cycle; busy is always low.
// The result of a taken item is registered in order by the input register, products,
// sums, plane compares and combine stages.
// Synchronous reset clears the valid bits and all plane registers to zero.
// Nothing stalls: the six plane lanes each have their own multipliers.
module frustum_cull_test
   import fct_pkg::*;
#(
   parameter int NORMAL_FRACTION_BITS = FCT_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // query channel
   input  logic                          start,
   output logic                          busy,
   input  fct_req_type                   req_data,
   // result channel
   output logic                          rsp_valid,
   output fct_rsp_type                   rsp_data,
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [FCT_CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [FCT_CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [FCT_CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                          csr_pready
);

   localparam int CB     = FCT_COORD_BITS;
   localparam int F      = NORMAL_FRACTION_BITS;
   localparam int MAXCF  = (CB > F) ? CB : F;
   localparam int ACC_A  = 19 + MAXCF;
   localparam int ACC_B  = CB + F + 2;
   localparam int ACC_W  = (ACC_A > ACC_B) ? ACC_A : ACC_B;
   localparam int PW     = FCT_COEF_BITS + CB;
   localparam int APW    = FCT_COEF_BITS + CB - 1;
   localparam int NP     = FCT_PLANES;
   localparam int CW     = FCT_COEF_BITS;

   // plane registers
   logic [FCT_CSR_DATA_BITS-1:0] plane_ff [NP];
   logic [FCT_CSR_DATA_BITS-1:0] plane_in [NP];
   logic [FCT_CSR_IDX_BITS-1:0]  csr_idx;
   logic                         csr_wr;

   assign csr_idx    = csr_paddr[FCT_CSR_ADDR_BITS-1:FCT_CSR_IDX_LSB];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_idx < FCT_CSR_IDX_BITS'(NP)) ? plane_ff[csr_idx] : '0;

   always_comb begin
      for (int p = 0; p < NP; p++) begin
         plane_in[p] = plane_ff[p];
      end
      if (csr_wr && (csr_idx < FCT_CSR_IDX_BITS'(NP))) begin
         plane_in[csr_idx] = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < NP; p++) begin
         if (reset) begin
            plane_ff[p] <= '0;
         end else begin
            plane_ff[p] <= plane_in[p];
         end
      end
   end

   // plane fields unpacked for the lanes
   logic signed [CW-1:0] coef_a [NP];
   logic signed [CW-1:0] coef_b [NP];
   logic signed [CW-1:0] coef_c [NP];
   logic signed [CW-1:0] coef_d [NP];
   logic [CW-1:0]        abs_a  [NP];
   logic [CW-1:0]        abs_b  [NP];
   logic [CW-1:0]        abs_c  [NP];

   always_comb begin
      for (int p = 0; p < NP; p++) begin
         coef_a[p] = plane_ff[p][63:48];
         coef_b[p] = plane_ff[p][47:32];
         coef_c[p] = plane_ff[p][31:16];
         coef_d[p] = plane_ff[p][15:0];
         abs_a[p]  = coef_a[p][CW-1] ? (~coef_a[p] + 1'b1) : coef_a[p];
         abs_b[p]  = coef_b[p][CW-1] ? (~coef_b[p] + 1'b1) : coef_b[p];
         abs_c[p]  = coef_c[p][CW-1] ? (~coef_c[p] + 1'b1) : coef_c[p];
      end
   end

   assign busy = 1'b0;

   // stage 0: input register
   logic        s0_valid_ff, s0_valid_in;
   fct_req_type s0_req_ff, s0_req_in;

   assign s0_valid_in = start & ~busy;
   assign s0_req_in   = req_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
      s0_req_ff <= s0_req_in;
   end

   // stage 1: centre products and extent products per plane
   logic                 s1_valid_ff, s1_valid_in;
   logic [1:0]           s1_kind_ff, s1_kind_in;
   logic [CB-2:0]        s1_radius_ff, s1_radius_in;
   logic signed [PW-1:0] s1_px_ff [NP], s1_px_in [NP];
   logic signed [PW-1:0] s1_py_ff [NP], s1_py_in [NP];
   logic signed [PW-1:0] s1_pz_ff [NP], s1_pz_in [NP];
   logic [APW-1:0]       s1_ex_ff [NP], s1_ex_in [NP];
   logic [APW-1:0]       s1_ey_ff [NP], s1_ey_in [NP];
   logic [APW-1:0]       s1_ez_ff [NP], s1_ez_in [NP];

   assign s1_valid_in  = s0_valid_ff;
   assign s1_kind_in   = s0_req_ff.kind;
   assign s1_radius_in = s0_req_ff.radius;

   always_comb begin
      for (int p = 0; p < NP; p++) begin
         s1_px_in[p] = PW'(coef_a[p]) * PW'(s0_req_ff.center_x);
         s1_py_in[p] = PW'(coef_b[p]) * PW'(s0_req_ff.center_y);
         s1_pz_in[p] = PW'(coef_c[p]) * PW'(s0_req_ff.center_z);
         s1_ex_in[p] = APW'(abs_a[p]) * APW'(s0_req_ff.half_x);
         s1_ey_in[p] = APW'(abs_b[p]) * APW'(s0_req_ff.half_y);
         s1_ez_in[p] = APW'(abs_c[p]) * APW'(s0_req_ff.half_z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_kind_ff   <= s1_kind_in;
      s1_radius_ff <= s1_radius_in;
      for (int p = 0; p < NP; p++) begin
         s1_px_ff[p] <= s1_px_in[p];
         s1_py_ff[p] <= s1_py_in[p];
         s1_pz_ff[p] <= s1_pz_in[p];
         s1_ex_ff[p] <= s1_ex_in[p];
         s1_ey_ff[p] <= s1_ey_in[p];
         s1_ez_ff[p] <= s1_ez_in[p];
      end
   end

   // stage 2: centre distance, box spread and sphere limit
   logic                    s2_valid_ff, s2_valid_in;
   logic [1:0]              s2_kind_ff, s2_kind_in;
   logic signed [ACC_W-1:0] s2_rlim_ff, s2_rlim_in;
   logic signed [ACC_W-1:0] s2_dc_ff [NP], s2_dc_in [NP];
   logic signed [ACC_W-1:0] s2_e_ff  [NP], s2_e_in  [NP];

   assign s2_valid_in = s1_valid_ff;
   assign s2_kind_in  = s1_kind_ff;
   assign s2_rlim_in  = signed'(ACC_W'(s1_radius_ff) << F);

   always_comb begin
      for (int p = 0; p < NP; p++) begin
         s2_dc_in[p] = ACC_W'(s1_px_ff[p]) + ACC_W'(s1_py_ff[p]) + ACC_W'(s1_pz_ff[p])
                     + (ACC_W'(coef_d[p]) <<< F);
         s2_e_in[p]  = signed'(ACC_W'(s1_ex_ff[p]) + ACC_W'(s1_ey_ff[p])
                     + ACC_W'(s1_ez_ff[p]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      s2_kind_ff <= s2_kind_in;
      s2_rlim_ff <= s2_rlim_in;
      for (int p = 0; p < NP; p++) begin
         s2_dc_ff[p] <= s2_dc_in[p];
         s2_e_ff[p]  <= s2_e_in[p];
      end
   end

   // stage 3: per-plane compares
   // box: farthest corner behind culls, nearest corner behind breaks inside
   logic                    s3_valid_ff, s3_valid_in;
   logic [1:0]              s3_kind_ff, s3_kind_in;
   logic [NP-1:0]           s3_neg_ff,  s3_neg_in;
   logic [NP-1:0]           s3_cull_ff, s3_cull_in;
   logic [NP-1:0]           s3_touch_ff, s3_touch_in;
   logic [NP-1:0]           s3_sph_ff,  s3_sph_in;
   logic signed [ACC_W-1:0] d_hi [NP];
   logic signed [ACC_W-1:0] d_lo [NP];
   logic signed [ACC_W-1:0] d_sp [NP];

   assign s3_valid_in = s2_valid_ff;
   assign s3_kind_in  = s2_kind_ff;

   always_comb begin
      for (int p = 0; p < NP; p++) begin
         d_hi[p]        = s2_dc_ff[p] + s2_e_ff[p];
         d_lo[p]        = s2_dc_ff[p] - s2_e_ff[p];
         d_sp[p]        = s2_dc_ff[p] + s2_rlim_ff;
         s3_neg_in[p]   = s2_dc_ff[p][ACC_W-1];
         s3_cull_in[p]  = d_hi[p][ACC_W-1];
         s3_touch_in[p] = d_lo[p][ACC_W-1];
         s3_sph_in[p]   = d_sp[p][ACC_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
      s3_kind_ff  <= s3_kind_in;
      s3_neg_ff   <= s3_neg_in;
      s3_cull_ff  <= s3_cull_in;
      s3_touch_ff <= s3_touch_in;
      s3_sph_ff   <= s3_sph_in;
   end

   // stage 4: combine planes by kind into the result register
   logic        rsp_valid_ff, rsp_valid_in;
   fct_rsp_type rsp_data_ff, rsp_data_in;

   assign rsp_valid_in = s3_valid_ff;

   always_comb begin
      rsp_data_in = '0;
      case (s3_kind_ff)
         KIND_POINT: begin
            rsp_data_in.visible = ~|s3_neg_ff;
         end
         KIND_BOX: begin
            rsp_data_in.visible      = ~|s3_cull_ff;
            rsp_data_in.fully_inside = ~|s3_cull_ff & ~|s3_touch_ff;
         end
         KIND_SPHERE: begin
            rsp_data_in.visible = ~|s3_sph_ff;
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/fct_checker.sv =====
// Port-level assertions for the frustum cull test block, with its bind.
module fct_checker
   import fct_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input fct_req_type req_data,
   input logic        rsp_valid,
   input fct_rsp_type rsp_data
);

   localparam int LATENCY = 5;

   // every result goes back to an item taken on the query channel
   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, LATENCY))
      else $error("result without a matching item");

   // fully inside only for a visible box
   a_inside_visible: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fully_inside |-> rsp_data.visible)
      else $error("fully_inside set on a culled item");

   a_inside_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fully_inside |-> $past(req_data.kind == KIND_BOX, LATENCY))
      else $error("fully_inside set for a non-box item");

   // the unused kind is never visible
   a_unused_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_data.kind != KIND_POINT && req_data.kind != KIND_BOX
                         && req_data.kind != KIND_SPHERE, LATENCY) |-> !rsp_data.visible)
      else $error("unused kind reported visible");

endmodule

bind frustum_cull_test fct_checker u_fct_checker (.*);
